// ===== sv/wildcard_pattern_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Wildcard pattern matcher assertion macros
// Shared concurrent-check wrappers on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define WPM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wildcard_pattern_matcher: same-cycle check failed");

// Next-cycle implication, checked at every clock edge out of reset.
`define WPM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wildcard_pattern_matcher: next-cycle check failed");

`endif

// ===== sv/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Sizes, command codes, wildcard bytes and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpm_pkg;

   localparam int PATTERN_MAX = 64;
   localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_APPEND  = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_SUBJECT = 2'd3;

   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] ANY_BYTE  = 8'h3F;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

// ===== sv/wildcard_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Glob matcher ('?' one byte, '*' any run) over a stored pattern, one
// dynamic-programming row held in a row memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_tuser carries the command (clear pattern, append pattern
//   byte, restart subject, subject byte), req_tdata the byte. One item is
//   taken at a time; req_tready is high while the controller is idle.
//   rsp channel: one item per request, rsp_tdata[0] = matched,
//   rsp_tdata[1] = pattern_full.
//   Flow: clear, a refused append, and a restart or subject byte with an
//   empty pattern go straight to the finish state. Append, restart and
//   subject bytes otherwise walk every stored pattern position through the
//   pattern and row memories, one read per cycle with write-back in the
//   following cycle. The finish state loads the output register once it is
//   free; rsp_tvalid is raised and req_tready returns in the same cycle.
//   A finished item sits in the output register while the next request is
//   accepted and walked; a stalled receiver only holds the block at the end
//   of the following walk.
//   Reset: synchronous, active high. It empties the pattern and restarts the
//   subject; no memory sweep is needed since only written entries are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_pattern_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] pattern_full, [7:2] zero
);
   import wpm_pkg::*;

   logic [7:0] pat_mem [PATTERN_MAX];
   logic       row_mem [PATTERN_MAX];   // entry j-1 holds row bit j

   state_type  state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [7:0] sym_ff, sym_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic       issue_ff, issue_in;
   logic       rd_valid_ff, rd_valid_in;
   logic       rd_last_ff, rd_last_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic       row0_ff, row0_in;
   logic       run_ff, run_in;
   logic       diag_ff, diag_in;
   logic       left_ff, left_in;
   logic       match_ff, match_in;
   logic       full_ff, full_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_match_ff, rsp_match_in;
   logic       rsp_full_ff, rsp_full_in;

   logic [7:0] pat_rd_ff;
   logic       row_rd_ff;

   logic [LEN_W-1:0] pos_dec;
   logic [IDX_W-1:0] rd_addr;
   logic       pat_we;
   logic       row_we;
   logic       nv;
   logic       slot_free;
   logic       accept;

   assign pos_dec   = pos_ff - LEN_W'(1);
   assign rd_addr   = pos_dec[IDX_W-1:0];
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;

   // Memories: registered read every cycle, write at the accept or write-back.
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[len_ff[IDX_W-1:0]] <= req_tdata;
      end
      if (row_we) begin
         row_mem[rd_idx_ff] <= nv;
      end
      pat_rd_ff <= pat_mem[rd_addr];
      row_rd_ff <= row_mem[rd_addr];
   end

   // New row bit for the position whose read data has just arrived.
   always_comb begin
      if (cmd_ff == CMD_SUBJECT) begin
         if (pat_rd_ff == STAR_BYTE) begin
            nv = left_ff | row_rd_ff;
         end else if (pat_rd_ff == ANY_BYTE || pat_rd_ff == sym_ff) begin
            nv = diag_ff;
         end else begin
            nv = 1'b0;
         end
      end else begin
         nv = run_ff && (pat_rd_ff == STAR_BYTE);
      end
   end

   // Datapath next values.
   always_comb begin
      cmd_in       = cmd_ff;
      sym_in       = sym_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_last_in   = rd_last_ff;
      rd_idx_in    = rd_idx_ff;
      row0_in      = row0_ff;
      run_in       = run_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      match_in     = match_ff;
      full_in      = full_ff;
      pat_we       = 1'b0;
      row_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_tuser;
               sym_in   = req_tdata;
               full_in  = 1'b0;
               pos_in   = LEN_W'(1);
               issue_in = 1'b0;
               case (req_tuser)
                  CMD_CLEAR: begin
                     len_in   = '0;
                     row0_in  = 1'b1;
                     match_in = 1'b1;
                  end
                  CMD_APPEND: begin
                     if (len_ff == LEN_W'(PATTERN_MAX)) begin
                        full_in = 1'b1;
                     end else begin
                        pat_we   = 1'b1;
                        len_in   = len_ff + LEN_W'(1);
                        row0_in  = 1'b1;
                        run_in   = 1'b1;
                        issue_in = 1'b1;
                     end
                  end
                  CMD_RESTART: begin
                     row0_in  = 1'b1;
                     run_in   = 1'b1;
                     match_in = 1'b1;
                     issue_in = (len_ff != '0);
                  end
                  default: begin
                     row0_in  = 1'b0;
                     diag_in  = row0_ff;
                     left_in  = 1'b0;
                     match_in = 1'b0;
                     issue_in = (len_ff != '0);
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_valid_in = issue_ff;
            if (issue_ff) begin
               rd_last_in = (pos_ff == len_ff);
               rd_idx_in  = rd_addr;
               pos_in     = pos_ff + LEN_W'(1);
               issue_in   = (pos_ff != len_ff);
            end
            // Write back the previous position; its address never equals the read one.
            if (rd_valid_ff) begin
               row_we  = 1'b1;
               run_in  = nv;
               left_in = nv;
               diag_in = row_rd_ff;
               if (rd_last_ff) begin
                  match_in = nv;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = issue_in ? ST_WALK : ST_FINISH;
            end
         end
         ST_WALK: begin
            if (rd_valid_ff && rd_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake and output register.
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      rsp_match_in = rsp_match_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_match_in = match_ff;
               rsp_full_in  = full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_full_ff, rsp_match_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         issue_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         row0_ff      <= 1'b1;
         match_ff     <= 1'b1;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         row0_ff      <= row0_in;
         match_ff     <= match_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      sym_ff       <= sym_in;
      pos_ff       <= pos_in;
      rd_last_ff   <= rd_last_in;
      rd_idx_ff    <= rd_idx_in;
      run_ff       <= run_in;
      diag_ff      <= diag_in;
      left_ff      <= left_in;
      rsp_match_ff <= rsp_match_in;
      rsp_full_ff  <= rsp_full_in;
   end

`include "wildcard_pattern_matcher_defines.svh"

   `WPM_ASSERT_SAME(a_no_rw_overlap,
                    state_ff == ST_WALK && issue_ff && rd_valid_ff,
                    rd_idx_ff != rd_addr)
   `WPM_ASSERT_SAME(a_len_bounded, 1'b1, len_ff <= LEN_W'(PATTERN_MAX))
   `WPM_ASSERT_NEXT(a_clear_result,
                    accept && req_tuser == CMD_CLEAR,
                    state_ff == ST_FINISH && match_ff && !full_ff && len_ff == '0)
   `WPM_ASSERT_NEXT(a_full_refused,
                    accept && req_tuser == CMD_APPEND && len_ff == LEN_W'(PATTERN_MAX),
                    full_ff && state_ff == ST_FINISH && $stable(len_ff))

endmodule
